// ===== rtl/core/dmxpm_pkg.sv =====
// Shared types and constants for the DMX universe pixel mapper.
// No dependencies; every other file of the block but the checker uses this package.
package dmxpm_pkg;

  // DMX universe geometry
  localparam int LOCAL_W    = 9;   // 512 channels per universe
  localparam int UNIVERSE_W = 16;
  localparam int BYTE_W     = 8;
  localparam int LANES      = 4;   // red, green, blue, white
  localparam int CPP_W      = 3;
  localparam logic [CPP_W-1:0] CPP_MAX = 3'd4;
  localparam logic [CPP_W-1:0] CPP_RESET = 3'd3;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_UNIVERSE    = 2'd0,
    REG_START_UNIVERSE     = 2'd1,
    REG_START_ADDRESS      = 2'd2,
    REG_CHANNELS_PER_PIXEL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [UNIVERSE_W-1:0] target_universe;
    logic [UNIVERSE_W-1:0] start_universe;
    logic [LOCAL_W-1:0]    start_address;
    logic [CPP_W-1:0]      channels_per_pixel;
  } cfg_t;

  // One pending channel write
  typedef struct packed {
    logic [LOCAL_W-1:0] address;
    logic [BYTE_W-1:0]  value;
  } slot_t;

  // All writes one pixel produces, with a mask of the ones that hit
  typedef struct packed {
    logic [LANES-1:0]         mask;
    slot_t [LANES-1:0]        slot;
  } batch_t;

endpackage

// ===== rtl/core/dmxpm_pixel_if.sv =====
// Pixel input channel: valid/ready handshake with four color bytes.
// Depends on dmxpm_pkg for field widths.
interface dmxpm_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [dmxpm_pkg::BYTE_W-1:0]  red;
  logic [dmxpm_pkg::BYTE_W-1:0]  green;
  logic [dmxpm_pkg::BYTE_W-1:0]  blue;
  logic [dmxpm_pkg::BYTE_W-1:0]  white;
  logic                          last_pixel;

  modport source (output valid, red, green, blue, white, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, white, last_pixel, output ready);
endinterface

// ===== rtl/core/dmxpm_write_if.sv =====
// Channel write output channel: valid/ready handshake with address and byte.
// Depends on dmxpm_pkg for field widths.
interface dmxpm_write_if;
  logic                          valid;
  logic                          ready;
  logic [dmxpm_pkg::LOCAL_W-1:0] channel_address;
  logic [dmxpm_pkg::BYTE_W-1:0]  channel_value;
  logic                          pixel_done;

  modport source (output valid, channel_address, channel_value, pixel_done, input ready);
  modport sink   (input valid, channel_address, channel_value, pixel_done, output ready);
endinterface

// ===== rtl/core/dmxpm_write_gen.sv =====
// Per-pixel channel position math: computes the four candidate writes.
// Depends on dmxpm_pkg (cfg_t, batch_t, widths).
module dmxpm_write_gen #(
  parameter int MAX_PIXELS = 1024,
  parameter int IDX_W      = $clog2(MAX_PIXELS + 1)
) (
  input  dmxpm_pkg::cfg_t                                  cfg,
  input  logic [IDX_W-1:0]                                 pixel_index,
  input  logic [dmxpm_pkg::LANES-1:0][dmxpm_pkg::BYTE_W-1:0] bytes,
  output dmxpm_pkg::batch_t                                batch
);

  localparam int MUL_W = IDX_W + dmxpm_pkg::CPP_W;
  localparam int SUM_W = (MUL_W > dmxpm_pkg::LOCAL_W) ? MUL_W : dmxpm_pkg::LOCAL_W;
  localparam int POS_W = SUM_W + 2;
  localparam int HI_W  = POS_W - dmxpm_pkg::LOCAL_W;
  localparam int UNI_W = ((HI_W > dmxpm_pkg::UNIVERSE_W) ? HI_W : dmxpm_pkg::UNIVERSE_W) + 1;

  logic [dmxpm_pkg::CPP_W-1:0] cpc;
  logic [MUL_W-1:0]            base;
  logic                        in_range;
  logic [POS_W-1:0]            pos [dmxpm_pkg::LANES];
  logic [UNI_W-1:0]            uni [dmxpm_pkg::LANES];

  // Channel count clamps to four; pixels past the store limit write nothing
  assign cpc = (cfg.channels_per_pixel > dmxpm_pkg::CPP_MAX) ? dmxpm_pkg::CPP_MAX
                                                               : cfg.channels_per_pixel;
  assign base     = MUL_W'(pixel_index) * MUL_W'(cpc);
  assign in_range = pixel_index < IDX_W'(MAX_PIXELS);

  // Each lane: global position, universe of that position, hit test
  always_comb begin
    for (int lane = 0; lane < dmxpm_pkg::LANES; lane++) begin
      pos[lane] = POS_W'(base) + POS_W'(cfg.start_address) + POS_W'(lane);
      uni[lane] = UNI_W'(cfg.start_universe) + UNI_W'(pos[lane] >> dmxpm_pkg::LOCAL_W);
      batch.mask[lane] = in_range && (dmxpm_pkg::CPP_W'(lane) < cpc)
                         && (uni[lane] == UNI_W'(cfg.target_universe));
      batch.slot[lane].address = pos[lane][dmxpm_pkg::LOCAL_W-1:0];
      batch.slot[lane].value   = bytes[lane];
    end
  end

endmodule

// ===== rtl/core/dmx_universe_pixel_mapper.sv =====
// DMX universe pixel mapper: maps fixture pixels to channel writes of one universe.
// Depends on dmxpm_pkg, dmxpm_pixel_if, dmxpm_write_if and dmxpm_write_gen.
// Latency: first write of a pixel is valid the cycle after the pixel transfer.
// Throughput: one pixel per cycle if it hits at most one channel and no write stalls;
// else its writes take the single write port in turn, the next pixel with the last.
// Reset (rst, synchronous): registers to defaults, pixel index to 0, no writes pending.
module dmx_universe_pixel_mapper #(
  parameter int MAX_PIXELS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [dmxpm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmxpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  dmxpm_pixel_if.sink                       pixels,
  dmxpm_write_if.source                     writes
);

  localparam int IDX_W = $clog2(MAX_PIXELS + 1);

  dmxpm_pkg::cfg_t   cfg;
  logic [IDX_W-1:0]  pixel_index;
  dmxpm_pkg::batch_t batch;
  dmxpm_pkg::batch_t pending;
  logic [dmxpm_pkg::LANES-1:0] head;
  logic [dmxpm_pkg::LANES-1:0] rest;
  dmxpm_pkg::slot_t  head_slot;
  logic              pixel_xfer;
  logic              write_xfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_universe    <= '0;
      cfg.start_universe     <= '0;
      cfg.start_address      <= '0;
      cfg.channels_per_pixel <= dmxpm_pkg::CPP_RESET;
    end else if (cfg_write_en) begin
      unique case (dmxpm_pkg::cfg_reg_t'(cfg_index))
        dmxpm_pkg::REG_TARGET_UNIVERSE:
          cfg.target_universe <= cfg_data[dmxpm_pkg::UNIVERSE_W-1:0];
        dmxpm_pkg::REG_START_UNIVERSE:
          cfg.start_universe <= cfg_data[dmxpm_pkg::UNIVERSE_W-1:0];
        dmxpm_pkg::REG_START_ADDRESS:
          cfg.start_address <= cfg_data[dmxpm_pkg::LOCAL_W-1:0];
        dmxpm_pkg::REG_CHANNELS_PER_PIXEL:
          cfg.channels_per_pixel <= cfg_data[dmxpm_pkg::CPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Candidate writes for the pixel on the input channel
  dmxpm_write_gen #(
    .MAX_PIXELS (MAX_PIXELS),
    .IDX_W      (IDX_W)
  ) u_write_gen (
    .cfg         (cfg),
    .pixel_index (pixel_index),
    .bytes       ({pixels.white, pixels.blue, pixels.green, pixels.red}),
    .batch       (batch)
  );

  // Lowest pending write goes out first; done when nothing remains behind it
  always_comb begin
    head      = '0;
    head_slot = pending.slot[0];
    for (int lane = dmxpm_pkg::LANES - 1; lane >= 0; lane--) begin
      if (pending.mask[lane]) begin
        head      = '0;
        head[lane] = 1'b1;
        head_slot = pending.slot[lane];
      end
    end
  end
  assign rest = pending.mask & ~head;

  assign writes.valid           = |pending.mask;
  assign writes.channel_address = head_slot.address;
  assign writes.channel_value   = head_slot.value;
  assign writes.pixel_done      = (rest == '0);

  assign write_xfer   = writes.valid && writes.ready;
  // Take a pixel once the pending batch is empty or its last write leaves now
  assign pixels.ready = !writes.valid || (write_xfer && (rest == '0));
  assign pixel_xfer   = pixels.valid && pixels.ready;

  // Pending write batch: mask is control, slots are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      pending.mask <= '0;
    end else if (pixel_xfer) begin
      pending.mask <= batch.mask;
    end else if (write_xfer) begin
      pending.mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_xfer) begin
      pending.slot <= batch.slot;
    end
  end

  // Pixel index: clears on last pixel, saturates at the store limit
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
    end else if (pixel_xfer) begin
      if (pixels.last_pixel) begin
        pixel_index <= '0;
      end else if (pixel_index < IDX_W'(MAX_PIXELS)) begin
        pixel_index <= pixel_index + IDX_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/dmxpm_checker.sv =====
// Port-level checks for the DMX universe pixel mapper, bound to the top level.
// Depends on dmx_universe_pixel_mapper's ports only.
module dmxpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_valid,
  input logic       pixel_ready,
  input logic       write_valid,
  input logic       write_ready,
  input logic [8:0] write_address,
  input logic [7:0] write_value,
  input logic       write_done
);

  // Stalled write holds valid
  assert property (@(posedge clk) disable iff (rst)
    write_valid && !write_ready |=> write_valid)
    else $error("write valid dropped while stalled");

  // Stalled write holds payload
  assert property (@(posedge clk) disable iff (rst)
    write_valid && !write_ready |=> $stable(write_address) && $stable(write_value)
                                    && $stable(write_done))
    else $error("write payload changed while stalled");

  // No write pending right after reset
  assert property (@(posedge clk) rst |=> !write_valid)
    else $error("write valid after reset");

  // No new pixel while writes of the current pixel remain
  assert property (@(posedge clk) disable iff (rst)
    write_valid && !(write_ready && write_done) |-> !pixel_ready)
    else $error("pixel taken while writes pending");

  // Final write transfer with no new pixel leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    write_valid && write_ready && write_done && !(pixel_valid && pixel_ready)
    |=> !write_valid)
    else $error("write appeared without a pixel");

endmodule

bind dmx_universe_pixel_mapper dmxpm_checker u_dmxpm_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_valid   (pixels.valid),
  .pixel_ready   (pixels.ready),
  .write_valid   (writes.valid),
  .write_ready   (writes.ready),
  .write_address (writes.channel_address),
  .write_value   (writes.channel_value),
  .write_done    (writes.pixel_done)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for dmx_universe_pixel_mapper: directed and random pixel
// streams, with a running model of the expected channel writes.
// Depends on dmxpm_pkg, dmxpm_pixel_if and dmxpm_write_if.
module tb_top;

  localparam int MAX_PIXELS    = 1024;
  localparam int UNIVERSE_SIZE = 512;
  localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer
  localparam int LONG_HOLD     = 200;   // output hold-off, in cycles
  localparam int DRAIN_CYCLES  = 8;     // pipeline flush before config and at the end
  localparam int MAX_PRINTS    = 40;

  typedef struct packed {
    logic [dmxpm_pkg::BYTE_W-1:0] red, green, blue, white;
    logic                         last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [dmxpm_pkg::LOCAL_W-1:0] channel_address;
    logic [dmxpm_pkg::BYTE_W-1:0]  channel_value;
    logic                          pixel_done;
  } chan_write_t;

  // Mirror of the mapper: registers, pixel index and the writes still owed
  class channel_write_tracker;
    dmxpm_pkg::cfg_t regs;
    int unsigned     pixel_index;
    chan_write_t     expected_writes[$];
    int              mismatches;
    int              writes_checked;

    function new();
      regs.target_universe    = '0;
      regs.start_universe     = '0;
      regs.start_address      = '0;
      regs.channels_per_pixel = dmxpm_pkg::CPP_RESET;
      pixel_index    = 0;
      mismatches     = 0;
      writes_checked = 0;
    endfunction

    function void apply_reg(dmxpm_pkg::cfg_reg_t idx,
                            logic [dmxpm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dmxpm_pkg::REG_TARGET_UNIVERSE:
          regs.target_universe    = data;
        dmxpm_pkg::REG_START_UNIVERSE:
          regs.start_universe     = data;
        dmxpm_pkg::REG_START_ADDRESS:
          regs.start_address      = data[dmxpm_pkg::LOCAL_W-1:0];
        dmxpm_pkg::REG_CHANNELS_PER_PIXEL:
          regs.channels_per_pixel = data[dmxpm_pkg::CPP_W-1:0];
        default: ;
      endcase
    endfunction

    // Channel positions are computed in 32 bits, so universe sums never wrap
    function void predict_pixel(pixel_t p);
      logic [dmxpm_pkg::BYTE_W-1:0]  lane_byte [dmxpm_pkg::LANES];
      logic [dmxpm_pkg::LOCAL_W-1:0] hit_addr [dmxpm_pkg::LANES];
      logic [dmxpm_pkg::BYTE_W-1:0]  hit_byte [dmxpm_pkg::LANES];
      int unsigned                   lanes_used, pos, uni;
      int                            hits;
      chan_write_t                   w;
      lane_byte[0] = p.red;
      lane_byte[1] = p.green;
      lane_byte[2] = p.blue;
      lane_byte[3] = p.white;
      lanes_used = (regs.channels_per_pixel > dmxpm_pkg::CPP_MAX) ?
                   32'(dmxpm_pkg::CPP_MAX) : 32'(regs.channels_per_pixel);
      hits = 0;
      // past the pixel store limit nothing is written
      if (pixel_index < MAX_PIXELS) begin
        for (int ch = 0; ch < lanes_used; ch++) begin
          pos = regs.start_address + pixel_index * lanes_used + ch;
          uni = regs.start_universe + pos / UNIVERSE_SIZE;
          if (uni == regs.target_universe) begin
            hit_addr[hits] = dmxpm_pkg::LOCAL_W'(pos % UNIVERSE_SIZE);
            hit_byte[hits] = lane_byte[ch];
            hits++;
          end
        end
      end
      for (int k = 0; k < hits; k++) begin
        w.channel_address = hit_addr[k];
        w.channel_value   = hit_byte[k];
        w.pixel_done      = (k == hits - 1);
        expected_writes   = {expected_writes, w};
      end
      if (p.last_pixel) begin
        pixel_index = 0;
      end else if (pixel_index < MAX_PIXELS) begin
        pixel_index++;
      end
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < MAX_PRINTS) begin
        $display("ERROR at write %0d: %s", writes_checked, msg);
      end
      mismatches++;
    endtask

    task check_write(chan_write_t got);
      chan_write_t want;
      if (expected_writes.size() == 0) begin
        flag_mismatch($sformatf("unexpected write addr %0d value 0x%02h done %0b",
                                got.channel_address, got.channel_value, got.pixel_done));
      end else begin
        want = expected_writes.pop_front();
        writes_checked++;
        if (got.channel_address !== want.channel_address) begin
          flag_mismatch($sformatf("channel_address %0d, expected %0d",
                                  got.channel_address, want.channel_address));
        end
        if (got.channel_value !== want.channel_value) begin
          flag_mismatch($sformatf("channel_value 0x%02h, expected 0x%02h",
                                  got.channel_value, want.channel_value));
        end
        if (got.pixel_done !== want.pixel_done) begin
          flag_mismatch($sformatf("pixel_done %0b, expected %0b",
                                  got.pixel_done, want.pixel_done));
        end
      end
    endtask
  endclass

  logic                              clk;
  logic                              rst;
  logic                              cfg_write_en;
  logic [dmxpm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dmxpm_pkg::CFG_DATA_W-1:0]  cfg_data;

  dmxpm_pixel_if pix();
  dmxpm_write_if wr();

  dmx_universe_pixel_mapper #(.MAX_PIXELS(MAX_PIXELS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixels       (pix),
    .writes       (wr)
  );

  channel_write_tracker tracker;
  int  idle_cycles   = 0;
  int  pixels_taken  = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  bit  offering      = 1'b0;
  int  rx_stall_pct  = 25;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  int  stall_left    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random short stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      wr.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      wr.ready <= 1'b0;
    end else if (stall_left > 0) begin
      wr.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      stall_left = $urandom_range(0, 5);
      wr.ready <= 1'b0;
    end else begin
      wr.ready <= 1'b1;
    end
  end

  // Transfer monitor: predicts on pixel transfers, checks write transfers
  always @(posedge clk) begin
    pixel_t      p;
    chan_write_t got;
    bit          moved;
    if (!rst) begin
      moved = 1'b0;
      if (pix.valid && pix.ready) begin
        p.red        = pix.red;
        p.green      = pix.green;
        p.blue       = pix.blue;
        p.white      = pix.white;
        p.last_pixel = pix.last_pixel;
        tracker.predict_pixel(p);
        pixels_taken++;
        moved = 1'b1;
      end
      if (wr.valid && wr.ready) begin
        got.channel_address = wr.channel_address;
        got.channel_value   = wr.channel_value;
        got.pixel_done      = wr.pixel_done;
        tracker.check_write(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Offer one pixel and hold it until the transfer; bursts end in a random gap
  task automatic send_pixel(input logic [dmxpm_pkg::BYTE_W-1:0] r, g, b, w,
                            input logic last);
    pix.valid      <= 1'b1;
    pix.red        <= r;
    pix.green      <= g;
    pix.blue       <= b;
    pix.white      <= w;
    pix.last_pixel <= last;
    offering = 1'b1;
    do @(posedge clk); while (pix.ready !== 1'b1);
    burst_left--;
    if (burst_left <= 0) begin
      pix.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic send_random_pixel(input logic last);
    send_pixel(dmxpm_pkg::BYTE_W'($urandom_range(0, 255)),
               dmxpm_pkg::BYTE_W'($urandom_range(0, 255)),
               dmxpm_pkg::BYTE_W'($urandom_range(0, 255)),
               dmxpm_pkg::BYTE_W'($urandom_range(0, 255)), last);
  endtask

  // Stop offering and wait until every owed write has arrived and the pipe is empty
  task automatic settle();
    if (offering) begin
      pix.valid <= 1'b0;
      offering = 1'b0;
    end
    // a clock edge first, so the monitor has logged the last pixel transfer
    @(posedge clk);
    while (tracker.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dmxpm_pkg::cfg_reg_t idx,
                           input logic [dmxpm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    tracker.apply_reg(idx, data);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic configure(input logic [dmxpm_pkg::CFG_DATA_W-1:0] tgt, src, addr, cpp);
    settle();
    write_reg(dmxpm_pkg::REG_TARGET_UNIVERSE, tgt);
    write_reg(dmxpm_pkg::REG_START_UNIVERSE, src);
    write_reg(dmxpm_pkg::REG_START_ADDRESS, addr);
    write_reg(dmxpm_pkg::REG_CHANNELS_PER_PIXEL, cpp);
    settings_used++;
  endtask

  // Random fixtures: runs of pixels closed by a last mark, with stray marks as noise
  task automatic random_phase(input int n_pixels, input int stall_pct, input bit long_hold);
    logic [dmxpm_pkg::UNIVERSE_W-1:0] base;
    int                               fixture_left;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      default: base = dmxpm_pkg::UNIVERSE_W'($urandom_range(0, 65535));
    endcase
    if (long_hold) begin
      configure(base, base, '0, dmxpm_pkg::CFG_DATA_W'(dmxpm_pkg::CPP_MAX));
    end else begin
      // target one past the base wraps to zero at the top, which must never match
      configure(base + dmxpm_pkg::UNIVERSE_W'($urandom_range(0, 1)), base,
                dmxpm_pkg::CFG_DATA_W'($urandom_range(0, 65535)),
                dmxpm_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
    end
    rx_stall_pct = stall_pct;
    if (long_hold) begin
      hold_req = 1'b1;
    end
    fixture_left = $urandom_range(1, 30);
    for (int i = 0; i < n_pixels; i++) begin
      fixture_left--;
      send_random_pixel(fixture_left == 0 || $urandom_range(0, 11) == 0);
      if (fixture_left == 0) begin
        fixture_left = $urandom_range(1, 30);
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_index      = dmxpm_pkg::REG_TARGET_UNIVERSE;
    cfg_data       = '0;
    pix.valid      = 1'b0;
    pix.red        = '0;
    pix.green      = '0;
    pix.blue       = '0;
    pix.white      = '0;
    pix.last_pixel = 1'b0;
    wr.ready       = 1'b0;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: three channels from address 0 of universe 0
    send_pixel(8'hFF, 8'h00, 8'hAA, 8'h55, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h55, 8'hAA, 1'b0);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);

    // top universe, last address: one write, the carry must not wrap to universe 0
    configure(16'hFFFF, 16'hFFFF, 16'd511, 16'd4);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    configure(16'h0000, 16'hFFFF, 16'd511, 16'd4);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);

    // zero channels: no writes, index still advances
    configure(16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0);
    send_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0);

    // channel counts above four behave as four
    configure(16'd0, 16'd0, 16'd0, 16'd7);
    send_pixel(8'h01, 8'h02, 8'h04, 8'h08, 1'b0);
    send_pixel(8'h10, 8'h20, 8'h40, 8'h80, 1'b1);
    configure(16'd0, 16'd0, 16'd0, 16'd5);
    send_pixel(8'hFE, 8'hFD, 8'hFB, 8'hF7, 1'b0);
    configure(16'd0, 16'd0, 16'd0, 16'd6);
    send_pixel(8'hEF, 8'hDF, 8'hBF, 8'h7F, 1'b1);

    // one and two channels across a universe boundary
    configure(16'd0, 16'd0, 16'd511, 16'd1);
    send_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
    send_pixel(8'h55, 8'h66, 8'h77, 8'h88, 1'b1);
    configure(16'd1, 16'd0, 16'd510, 16'd2);
    send_pixel(8'h99, 8'hAA, 8'hBB, 8'hCC, 1'b0);
    send_pixel(8'hDD, 8'hEE, 8'hFF, 8'h00, 1'b1);

    // random fixtures; the first one runs into the long output hold-off
    random_phase(24, 10, 1'b1);
    random_phase(14, 30, 1'b0);
    random_phase(14, 0, 1'b0);
    random_phase(14, 50, 1'b0);
    random_phase(14, 20, 1'b0);
    random_phase(14, 10, 1'b0);
    random_phase(14, 40, 1'b0);

    settle();
    $display("Run: %0d pixels over %0d register settings, with boundary and clamp cases",
             pixels_taken, settings_used);
    $display("and a %0d-cycle output hold-off; %0d channel writes checked, %0d errors.",
             LONG_HOLD, tracker.writes_checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
